FILE: rtl/ideg_pkg.sv
// Shared types and constants of the image deglitch filter.
// Holds input operation codes, register indexes and the control/status
// structs between the sequencer and the datapath. No dependencies.
package ideg_pkg;

	// operation codes of the input beat
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// configuration registers, indexed by paddr[3:2]
	localparam int          REG_ADDR_BITS  = 4;
	localparam logic [1:0]  REG_WIDTH      = 2'd0;
	localparam logic [1:0]  REG_HEIGHT     = 2'd1;
	localparam logic [1:0]  REG_THRESHOLD  = 2'd2;

	localparam logic [10:0] WIDTH_RESET     = 11'd30;
	localparam logic [15:0] HEIGHT_RESET    = 16'd20;
	localparam logic [7:0]  THRESHOLD_RESET = 8'd1;

	// sequencer to datapath
	typedef struct packed {
		logic load;      // capture the input pixel
		logic rd;        // read line store at column and column + 1
		logic eval;      // evaluate neighbors
		logic wr;        // shift the column of the line stores
		logic filt;      // this beat produces an output pixel
		logic has_left;
		logic has_right;
		logic has_up;
		logic has_down;
		logic mul;       // reciprocal multiply stage
		logic fin;       // load the output register
		logic last;      // final pixel of the frame
	} ideg_cmd_t;

	// datapath to sequencer
	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
	} ideg_sts_t;

endpackage

FILE: rtl/ideg_ctrl.sv
// Sequencer of the image deglitch filter: frame counters and item steps.
// Depends on ideg_pkg; drives ideg_dp through ideg_cmd_t.
module ideg_ctrl #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   op,
	input  logic [((($clog2(MAX_WIDTH + 1)) > 11) ? $clog2(MAX_WIDTH + 1) : 11)-1:0] eff_w,
	input  logic [15:0]                            eff_h,
	input  ideg_pkg::ideg_sts_t                    sts,
	output ideg_pkg::ideg_cmd_t                    cmd,
	output logic [$clog2(MAX_WIDTH)-1:0]           col
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int CW = (EW > 11) ? EW : 11;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] col_cnt_q;
	logic [15:0]   row_q;
	logic          flushing_q;
	logic [AW-1:0] item_col_q;
	logic          pix_q, filt_q, left_q, right_q, up_q, down_q, last_q;

	logic accept, col_last, row_last, take_pixel, take_flush;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign col_last = (CW'(col_cnt_q) + CW'(1)) >= eff_w;
	assign row_last = ({1'b0, row_q} + 17'd1) >= {1'b0, eff_h};
	assign take_pixel = accept && (op == ideg_pkg::OP_PIXEL) && !flushing_q;
	assign take_flush = accept && (op == ideg_pkg::OP_FLUSH) && flushing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_cnt_q  <= '0;
			row_q      <= '0;
			flushing_q <= 1'b0;
			item_col_q <= '0;
			pix_q      <= 1'b0;
			filt_q     <= 1'b0;
			left_q     <= 1'b0;
			right_q    <= 1'b0;
			up_q       <= 1'b0;
			down_q     <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take_pixel || take_flush) begin
						item_col_q <= col_cnt_q;
						left_q     <= (col_cnt_q != '0);
						right_q    <= !col_last;
						pix_q      <= take_pixel;
						state_q    <= ST_READ;
					end
					if (take_pixel) begin
						filt_q <= (row_q != 16'd0);
						up_q   <= (row_q >= 16'd2);
						down_q <= 1'b1;
						last_q <= 1'b0;
						if (col_last) begin
							col_cnt_q <= '0;
							if (row_last) begin
								flushing_q <= 1'b1;
							end else begin
								row_q <= row_q + 16'd1;
							end
						end else begin
							col_cnt_q <= col_cnt_q + AW'(1);
						end
					end else if (take_flush) begin
						// emit one pixel of the last row, no row below
						filt_q <= 1'b1;
						up_q   <= (row_q != 16'd0);
						down_q <= 1'b0;
						last_q <= col_last;
						if (col_last) begin
							flushing_q <= 1'b0;
							col_cnt_q  <= '0;
							row_q      <= '0;
						end else begin
							col_cnt_q <= col_cnt_q + AW'(1);
						end
					end
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: state_q <= filt_q ? ST_MUL : ST_IDLE;
				ST_MUL:  state_q <= ST_FIN;
				ST_FIN: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign col = item_col_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.rd        = (state_q == ST_READ);
		cmd.eval      = (state_q == ST_EVAL);
		cmd.wr        = (state_q == ST_EVAL) && pix_q;
		cmd.filt      = filt_q;
		cmd.has_left  = left_q;
		cmd.has_right = right_q;
		cmd.has_up    = up_q;
		cmd.has_down  = down_q;
		cmd.mul       = (state_q == ST_MUL);
		cmd.fin       = (state_q == ST_FIN) && sts.out_free;
		cmd.last      = last_q;
	end

endmodule

FILE: rtl/ideg_dp.sv
// Datapath of the image deglitch filter: line store memory, neighbor test,
// rounded average and output register. Depends on ideg_pkg; run by ideg_ctrl.
module ideg_dp #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ideg_pkg::ideg_cmd_t           cmd,
	output ideg_pkg::ideg_sts_t           sts,
	input  logic [$clog2(MAX_WIDTH)-1:0]  col,
	input  logic [PIXEL_BITS-1:0]         pixel_in,
	input  logic [7:0]                    thr,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [PIXEL_BITS-1:0]         pixel_out,
	output logic                          replaced,
	output logic                          last_of_frame
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PB = PIXEL_BITS;
	localparam int SW = PB + 2;           // sum of up to four neighbors
	localparam int XW = PB + 3;           // 2*sum + count
	localparam int DW = (PB > 8) ? PB : 8;
	localparam int RS = PB + 4;           // reciprocal shift
	localparam logic [PB+2:0] RECIP3 = (PB+3)'((1 << RS) / 3);

	// each word holds {upper row, middle row} of one column
	logic [2*PB-1:0] line_mem [MAX_WIDTH];

	logic [PB-1:0]   px_q, held_left_q;
	logic [2*PB-1:0] rd_c_q, rd_n_q;

	logic [PB-1:0] centre, nb_up, nb_right;
	logic [SW-1:0] sum;
	logic [2:0]    cnt;
	logic          all_differ;

	logic [SW-1:0] sum_s1;
	logic [2:0]    cnt_s1;
	logic          glitch_s1;
	logic [PB-1:0] centre_s1;

	logic [XW-1:0]      x_mul;
	logic [SW-1:0]      y_mul;
	logic [2*PB+4:0]    prod;
	logic [XW-1:0]      x_s2;
	logic [PB:0]        q0_s2;
	logic [2:0]         cnt_s2;
	logic               glitch_s2;
	logic [PB-1:0]      centre_s2;

	logic [XW-1:0] rem3;
	logic [PB:0]   q3;
	logic [XW-1:0] avg;
	logic [PB-1:0] result;

	logic          out_valid_q, replaced_q, last_q;
	logic [PB-1:0] pixel_out_q;

	function automatic logic differs(input logic [PB-1:0] nb, input logic [PB-1:0] c,
	                                 input logic [7:0] t);
		logic [PB-1:0] d;
		d = (nb > c) ? (nb - c) : (c - nb);
		return DW'(d) > DW'(t);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pixel_in;
		end
		if (cmd.rd) begin
			rd_c_q <= line_mem[col];
			rd_n_q <= line_mem[col + AW'(1)];
		end
		if (cmd.wr) begin
			line_mem[col] <= {rd_c_q[PB-1:0], px_q};
		end
	end

	assign centre   = rd_c_q[PB-1:0];
	assign nb_up    = rd_c_q[2*PB-1:PB];
	assign nb_right = rd_n_q[PB-1:0];

	always_comb begin
		sum        = '0;
		cnt        = '0;
		all_differ = 1'b1;
		if (cmd.has_left) begin
			sum = sum + SW'(held_left_q);
			cnt = cnt + 3'd1;
			if (!differs(held_left_q, centre, thr)) all_differ = 1'b0;
		end
		if (cmd.has_right) begin
			sum = sum + SW'(nb_right);
			cnt = cnt + 3'd1;
			if (!differs(nb_right, centre, thr)) all_differ = 1'b0;
		end
		if (cmd.has_up) begin
			sum = sum + SW'(nb_up);
			cnt = cnt + 3'd1;
			if (!differs(nb_up, centre, thr)) all_differ = 1'b0;
		end
		if (cmd.has_down) begin
			sum = sum + SW'(px_q);
			cnt = cnt + 3'd1;
			if (!differs(px_q, centre, thr)) all_differ = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_left_q <= '0;
		end else if (cmd.eval && cmd.filt) begin
			held_left_q <= centre;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			sum_s1    <= sum;
			cnt_s1    <= cnt;
			glitch_s1 <= (cnt != 3'd0) && all_differ;
			centre_s1 <= centre;
		end
	end

	// divide by six as (x/2)/3 through a reciprocal, corrected in the next step
	assign x_mul = {sum_s1, 1'b0} + XW'(cnt_s1);
	assign y_mul = x_mul[XW-1:1];
	assign prod  = (2*PB+5)'(y_mul) * (2*PB+5)'(RECIP3);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			x_s2      <= x_mul;
			q0_s2     <= prod[2*PB+4:RS];
			cnt_s2    <= cnt_s1;
			glitch_s2 <= glitch_s1;
			centre_s2 <= centre_s1;
		end
	end

	assign rem3 = XW'(x_s2[XW-1:1]) - (XW'(q0_s2) + XW'({q0_s2, 1'b0}));
	assign q3   = (rem3 >= XW'(3)) ? (q0_s2 + (PB+1)'(1)) : q0_s2;

	always_comb begin
		unique case (cnt_s2)
			3'd1:    avg = x_s2 >> 1;
			3'd2:    avg = x_s2 >> 2;
			3'd3:    avg = XW'(q3);
			3'd4:    avg = x_s2 >> 3;
			default: avg = '0;
		endcase
		result = glitch_s2 ? avg[PB-1:0] : centre_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			pixel_out_q <= result;
			replaced_q  <= glitch_s2;
			last_q      <= cmd.last;
		end
	end

	assign sts.out_free  = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign pixel_out     = pixel_out_q;
	assign replaced      = replaced_q;
	assign last_of_frame = last_q;

endmodule

FILE: rtl/image_deglitch_filter_unit.sv
// Image deglitch filter: raster pixels in, the frame one row behind out.
// A pixel that differs by more than glitch_threshold from each of its left,
// right, up and down neighbors is replaced by their rounded average.
// Input beat: op and pixel_in under in_valid/in_stall. op = pixel feeds the
// raster stream; once the last row is in, op = flush beats drain it, one
// output each, the last one flagged last_of_frame. Beats that do not fit
// (pixel while draining, flush otherwise) are taken and dropped.
// Output beat: pixel_out, replaced, last_of_frame under out_valid/out_stall.
// Timing: one item at a time. A beat that yields a pixel goes through line
// store read, neighbor test, reciprocal multiply, correction and output load;
// a beat of the first row only through the read and the neighbor test, and a
// dropped beat through none of them. The output pixel is registered. While the
// receiver stalls, the result holds in the output register and the next item
// waits in its last step; the input stalls meanwhile.
// Reset clears counters and control, loads register defaults (30 x 20,
// threshold 1); line store contents are undefined until written.
// Registers over APB at 0x0 width, 0x4 height, 0x8 threshold.
module image_deglitch_filter_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ideg_pkg::REG_ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [PIXEL_BITS-1:0]                pixel_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [PIXEL_BITS-1:0]                pixel_out,
	output logic                                 replaced,
	output logic                                 last_of_frame
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int CW = (EW > 11) ? EW : 11;

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [7:0]  thr_q;
	logic        wr_en;

	logic [CW-1:0] width_ext, eff_w;
	logic [15:0]   eff_h;

	ideg_pkg::ideg_cmd_t cmd;
	ideg_pkg::ideg_sts_t sts;
	logic [AW-1:0]       col;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ideg_pkg::WIDTH_RESET;
			height_q <= ideg_pkg::HEIGHT_RESET;
			thr_q    <= ideg_pkg::THRESHOLD_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				ideg_pkg::REG_WIDTH:     width_q  <= pwdata[10:0];
				ideg_pkg::REG_HEIGHT:    height_q <= pwdata[15:0];
				ideg_pkg::REG_THRESHOLD: thr_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ideg_pkg::REG_WIDTH:     prdata = {21'd0, width_q};
			ideg_pkg::REG_HEIGHT:    prdata = {16'd0, height_q};
			ideg_pkg::REG_THRESHOLD: prdata = {24'd0, thr_q};
			default:                 prdata = '0;
		endcase
	end

	// clamp the frame width to what the line stores hold; a zero width or height counts as one
	assign width_ext = CW'(width_q);
	always_comb begin
		if (width_ext == '0) begin
			eff_w = CW'(1);
		end else if (width_ext > CW'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = width_ext;
		end
	end
	assign eff_h = (height_q == 16'd0) ? 16'd1 : height_q;

	ideg_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.sts      (sts),
		.cmd      (cmd),
		.col      (col)
	);

	ideg_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.col           (col),
		.pixel_in      (pixel_in),
		.thr           (thr_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_out     (pixel_out),
		.replaced      (replaced),
		.last_of_frame (last_of_frame)
	);

endmodule
